// ===== hw/rtl/bvrs_pkg.sv =====
// Shared constants, command and status codes, and controller/datapath types.
package bvrs_pkg;

    localparam int WORD_WIDTH     = 64;
    localparam int WORDS_PER_LINE = 4;
    localparam int STORE_WORDS    = 1024;

    localparam int LINE_BITS     = WORD_WIDTH * WORDS_PER_LINE;
    localparam int LINE_MAX      = (STORE_WORDS + WORDS_PER_LINE - 1) / WORDS_PER_LINE;
    localparam int CAPACITY_BITS = STORE_WORDS * WORD_WIDTH;

    localparam int CMD_W   = 3;
    localparam int WIDX_W  = 10;
    localparam int DATA_W  = 64;
    localparam int QUERY_W = 16;
    localparam int ANS_W   = 17;
    localparam int ST_W    = 2;
    localparam int CNT_W   = 17;

    localparam int WADDR_W = $clog2(STORE_WORDS);
    localparam int LINE_W  = $clog2(LINE_MAX + 1);
    localparam int BIT_W   = $clog2(WORD_WIDTH);
    localparam int NBYTES  = WORD_WIDTH / 8;
    localparam int BYTE_W  = $clog2(NBYTES);

    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RANK1   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SELECT1 = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SELECT0 = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [ST_W-1:0] ST_UNBUILT = 2'd2;

    typedef enum logic [2:0] {
        RES_OK      = 3'd0,
        RES_RANGE   = 3'd1,
        RES_UNBUILT = 3'd2,
        RES_ACC     = 3'd3,
        RES_POS     = 3'd4
    } res_t;

    typedef struct packed {
        logic load;
        logic wr_word;
        logic b_init;
        logic word_rd;
        logic b_wr;
        logic b_end;
        logic r_rd_rank;
        logic r_init;
        logic r_acc;
        logic s_init;
        logic s_rd_mid;
        logic s_cmp;
        logic s_rd_hit;
        logic s_hit;
        logic s_found;
        logic s_next;
        logic s_byte;
        logic res_set;
        res_t res_code;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic widx_ok;
        logic dir_valid;
        logic lines_zero;
        logic q_ok;
        logic build_last;
        logic rank_last;
        logic lo_lt_hi;
        logic lo_zero;
        logic hit_found;
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

// ===== hw/rtl/bvrs_if.sv =====
// Request and response channel interfaces.
interface bvrs_req_if import bvrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [WIDX_W-1:0]  word_index;
    logic [DATA_W-1:0]  word_data;
    logic [QUERY_W-1:0] query;

    modport source (output valid, command, word_index, word_data, query, input ready);
    modport sink   (input valid, command, word_index, word_data, query, output ready);
endinterface

interface bvrs_rsp_if import bvrs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ANS_W-1:0] answer;
    logic [ST_W-1:0]  status;

    modport source (output valid, answer, status, input ready);
    modport sink   (input valid, answer, status, output ready);
endinterface

// ===== hw/rtl/bitvector_rank_select.sv =====
// Top level of the rank/select bit vector block.
//
// Usage: a request transaction on req carries a command (write word, build,
// rank1, select1, select0) with word_index, word_data and query; each request
// yields exactly one response transaction on rsp with answer and status.
// cfg_we/cfg_wdata set the vector length; write it only while idle. It and
// every word write mark the directory stale, so issue a build before queries.
// One request is worked at a time; req.ready is high only while idle.
// Rank1 reads the directory, then one word at a time up to the position;
// select1/select0 search the directory (at most 9 steps), then scan the
// words of the found line (at most 4); build reads and rewrites each word
// of the used lines.
// The result sits in an output register; the next request is taken while it
// waits. When rsp stalls, a finished request holds in the controller until
// the output register frees.
// Reset clears the length, the total, the directory flag and the response
// valid; store contents are undefined until written.
module bitvector_rank_select import bvrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    bvrs_req_if.sink         req,
    bvrs_rsp_if.source       rsp
);

    ctl_t  ctl;
    stat_t stat;

    bvrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    bvrs_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .command    (req.command),
        .word_index (req.word_index),
        .word_data  (req.word_data),
        .query      (req.query),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .answer     (rsp.answer),
        .status     (rsp.status),
        .ctl        (ctl),
        .stat       (stat)
    );

    // Hold off new requests for the cycle after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while one is in flight");

    // Drop the directory on a length change
    a_cfg_clears_dir: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !stat.dir_valid)
        else $error("directory still valid after length write");

    // Hold the answer at zero on any error status
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.answer == '0))
        else $error("nonzero answer with error status");

endmodule

// ===== hw/rtl/bvrs_datapath.sv =====
// Datapath: word store, line directory, counters, search and result registers.
module bvrs_datapath import bvrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic [CMD_W-1:0]   command,
    input  logic [WIDX_W-1:0]  word_index,
    input  logic [DATA_W-1:0]  word_data,
    input  logic [QUERY_W-1:0] query,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [ANS_W-1:0]   answer,
    output logic [ST_W-1:0]    status,
    input  ctl_t               ctl,
    output stat_t              stat
);

    function automatic logic [BIT_W:0] popcount(input logic [WORD_WIDTH-1:0] v);
        logic [BIT_W:0] c;
        c = '0;
        for (int i = 0; i < WORD_WIDTH; i++)
        begin
            c = c + (BIT_W+1)'(v[i]);
        end
        return c;
    endfunction

    function automatic logic [WORD_WIDTH-1:0] low_mask(input logic [BIT_W-1:0] s);
        return ~({WORD_WIDTH{1'b1}} << s);
    endfunction

    logic [WORD_WIDTH-1:0] word_mem [STORE_WORDS];
    logic [CNT_W-1:0]      rank_mem [LINE_MAX+1];
    logic [WORD_WIDTH-1:0] word_q;
    logic [CNT_W-1:0]      rank_q;

    logic [CNT_W-1:0]      bit_count_reg;
    logic                  dir_valid_reg;
    logic [CNT_W-1:0]      total_reg;
    logic                  out_valid_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [WIDX_W-1:0]     widx_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic [QUERY_W-1:0]    query_reg;
    logic [WADDR_W-1:0]    wptr_reg;
    logic [CNT_W-1:0]      acc_reg;
    logic [LINE_W-1:0]     lo_reg;
    logic [LINE_W-1:0]     hi_reg;
    logic [LINE_W-1:0]     mid_reg;
    logic [WORD_WIDTH-1:0] v_reg;
    logic [BIT_W-1:0]      rem_reg;
    logic [7:0]            byte_reg;
    logic [BYTE_W-1:0]     bidx_reg;
    logic [2:0]            brem_reg;
    logic [ANS_W-1:0]      res_ans_reg;
    logic [ST_W-1:0]       res_st_reg;
    logic [ANS_W-1:0]      ans_reg;
    logic [ST_W-1:0]       st_reg;

    logic [CNT_W-1:0]      n;
    logic [LINE_W-1:0]     lines;
    logic                  zeros;
    logic [CNT_W-1:0]      k;
    logic [LINE_W-1:0]     q_line;
    logic [WADDR_W-1:0]    q_last;
    logic [BIT_W-1:0]      q_sh;
    logic [CNT_W-1:0]      base;
    logic [CNT_W-1:0]      diff;
    logic [WORD_WIDTH-1:0] build_mask;
    logic [WORD_WIDTH-1:0] build_word;
    logic [WORD_WIDTH-1:0] scan_v;
    logic [WORD_WIDTH-1:0] pc_in;
    logic [BIT_W:0]        pc;
    logic [CNT_W-1:0]      acc_plus;
    logic [LINE_W-1:0]     mid_next;
    logic [LINE_W-1:0]     lo_m1;
    logic [CNT_W-1:0]      before_mid;
    logic [CNT_W-1:0]      before_lo;
    logic                  word_we;
    logic [WADDR_W-1:0]    word_wa;
    logic [WORD_WIDTH-1:0] word_wd;
    logic                  rank_we;
    logic [LINE_W-1:0]     rank_wa;
    logic                  rank_re;
    logic [LINE_W-1:0]     rank_ra;
    logic [BYTE_W-1:0]     sel_b;
    logic [2:0]            sel_brem;
    logic [7:0]            sel_byte;
    logic [2:0]            sel_bit;
    logic [CNT_W-1:0]      pos;

    // Effective length is capped at the store capacity
    assign n = (bit_count_reg > CNT_W'(CAPACITY_BITS)) ? CNT_W'(CAPACITY_BITS) : bit_count_reg;
    assign lines  = LINE_W'(({1'b0, n} + (CNT_W+1)'(LINE_BITS - 1)) / LINE_BITS);
    assign zeros  = (cmd_reg == CMD_SELECT0);
    assign k      = CNT_W'(query_reg);
    assign q_line = LINE_W'(query_reg / LINE_BITS);
    assign q_last = WADDR_W'(query_reg / WORD_WIDTH);
    assign q_sh   = BIT_W'(query_reg % WORD_WIDTH);

    // Build mask: clear bits at and past the vector length
    assign base = CNT_W'(int'(wptr_reg) * WORD_WIDTH);
    assign diff = n - base;
    always_comb
    begin
        if (base >= n)
            build_mask = '0;
        else if (diff < CNT_W'(WORD_WIDTH))
            build_mask = low_mask(diff[BIT_W-1:0]);
        else
            build_mask = '1;
    end
    assign build_word = word_q & build_mask;
    assign scan_v     = zeros ? ~word_q : word_q;

    always_comb
    begin
        if (cmd_reg == CMD_BUILD)
            pc_in = build_word;
        else if (cmd_reg == CMD_RANK1)
            pc_in = (wptr_reg == q_last) ? (word_q & low_mask(q_sh)) : word_q;
        else
            pc_in = scan_v;
    end
    assign pc       = popcount(pc_in);
    assign acc_plus = acc_reg + CNT_W'(pc);

    assign mid_next   = LINE_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign lo_m1      = lo_reg - LINE_W'(1);
    assign before_mid = zeros ? (CNT_W'(int'(mid_reg) * LINE_BITS) - rank_q) : rank_q;
    assign before_lo  = zeros ? (CNT_W'(int'(lo_m1) * LINE_BITS) - rank_q) : rank_q;

    // Byte search for the wanted set bit inside the latched word
    always_comb
    begin
        logic [BIT_W:0] cum;
        logic [3:0]     bpc;
        logic           found;
        cum      = '0;
        found    = 1'b0;
        sel_b    = '0;
        sel_brem = '0;
        for (int b = 0; b < NBYTES; b++)
        begin
            bpc = 4'(popcount(WORD_WIDTH'(v_reg[b*8 +: 8])));
            if (!found && ((cum + (BIT_W+1)'(bpc)) > (BIT_W+1)'(rem_reg)))
            begin
                found    = 1'b1;
                sel_b    = BYTE_W'(b);
                sel_brem = 3'((BIT_W+1)'(rem_reg) - cum);
            end
            cum = cum + (BIT_W+1)'(bpc);
        end
    end
    assign sel_byte = v_reg[int'(sel_b)*8 +: 8];

    always_comb
    begin
        logic [2:0] cnt;
        logic       found;
        cnt     = '0;
        found   = 1'b0;
        sel_bit = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (byte_reg[i] && !found)
            begin
                if (cnt == brem_reg)
                begin
                    found   = 1'b1;
                    sel_bit = 3'(i);
                end
                else
                    cnt = cnt + 3'd1;
            end
        end
    end
    assign pos = CNT_W'(int'(wptr_reg) * WORD_WIDTH) + CNT_W'({bidx_reg, 3'b000})
               + CNT_W'(sel_bit);

    // Memories
    assign word_we = ctl.wr_word | ctl.b_wr;
    assign word_wa = ctl.wr_word ? WADDR_W'(widx_reg) : wptr_reg;
    assign word_wd = ctl.wr_word ? WORD_WIDTH'(wdata_reg) : build_word;

    always_ff @(posedge clk)
    begin
        if (word_we)
            word_mem[word_wa] <= word_wd;
        if (ctl.word_rd)
            word_q <= word_mem[wptr_reg];
    end

    assign rank_we = (ctl.b_wr && ((int'(wptr_reg) % WORDS_PER_LINE) == 0)) || ctl.b_end;
    assign rank_wa = ctl.b_end ? lines : LINE_W'(wptr_reg / WORDS_PER_LINE);
    assign rank_re = ctl.r_rd_rank | ctl.s_rd_mid | ctl.s_rd_hit;
    assign rank_ra = ctl.r_rd_rank ? q_line : (ctl.s_rd_mid ? mid_next : lo_m1);

    always_ff @(posedge clk)
    begin
        if (rank_we)
            rank_mem[rank_wa] <= acc_reg;
        if (rank_re)
            rank_q <= rank_mem[rank_ra];
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= '0;
            dir_valid_reg <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                bit_count_reg <= cfg_wdata;
            if (cfg_we || ctl.wr_word)
                dir_valid_reg <= 1'b0;
            else if (ctl.b_end)
                dir_valid_reg <= 1'b1;
            if (ctl.b_end)
                total_reg <= acc_reg;
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= command;
            widx_reg  <= word_index;
            wdata_reg <= word_data;
            query_reg <= query;
        end
        if (ctl.b_init)
        begin
            wptr_reg <= '0;
            acc_reg  <= '0;
        end
        if (ctl.b_wr || ctl.r_acc || ctl.s_next)
        begin
            acc_reg  <= acc_plus;
            wptr_reg <= wptr_reg + WADDR_W'(1);
        end
        if (ctl.r_init)
        begin
            acc_reg  <= rank_q;
            wptr_reg <= WADDR_W'(int'(q_line) * WORDS_PER_LINE);
        end
        if (ctl.s_init)
        begin
            lo_reg <= '0;
            hi_reg <= lines;
        end
        if (ctl.s_rd_mid)
            mid_reg <= mid_next;
        if (ctl.s_cmp)
        begin
            if (before_mid <= k)
                lo_reg <= mid_reg + LINE_W'(1);
            else
                hi_reg <= mid_reg;
        end
        if (ctl.s_hit)
        begin
            acc_reg  <= before_lo;
            wptr_reg <= WADDR_W'(int'(lo_m1) * WORDS_PER_LINE);
        end
        if (ctl.s_found)
        begin
            v_reg   <= scan_v;
            rem_reg <= BIT_W'(k - acc_reg);
        end
        if (ctl.s_byte)
        begin
            byte_reg <= sel_byte;
            bidx_reg <= sel_b;
            brem_reg <= sel_brem;
        end
        if (ctl.res_set)
        begin
            unique case (ctl.res_code)
                RES_OK:
                begin
                    res_ans_reg <= '0;
                    res_st_reg  <= ST_OK;
                end
                RES_RANGE:
                begin
                    res_ans_reg <= '0;
                    res_st_reg  <= ST_RANGE;
                end
                RES_UNBUILT:
                begin
                    res_ans_reg <= '0;
                    res_st_reg  <= ST_UNBUILT;
                end
                RES_ACC:
                begin
                    res_ans_reg <= ANS_W'(acc_reg);
                    res_st_reg  <= ST_OK;
                end
                RES_POS:
                begin
                    res_ans_reg <= ANS_W'(pos);
                    res_st_reg  <= ST_OK;
                end
                default:
                begin
                    res_ans_reg <= '0;
                    res_st_reg  <= ST_RANGE;
                end
            endcase
        end
        if (ctl.out_load)
        begin
            ans_reg <= res_ans_reg;
            st_reg  <= res_st_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign answer    = ans_reg;
    assign status    = st_reg;

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.widx_ok    = ({1'b0, widx_reg} < (WIDX_W+1)'(STORE_WORDS));
        stat.dir_valid  = dir_valid_reg;
        stat.lines_zero = (lines == '0);
        if (cmd_reg == CMD_RANK1)
            stat.q_ok = (k < n);
        else if (cmd_reg == CMD_SELECT1)
            stat.q_ok = (k < total_reg);
        else
            stat.q_ok = (k < (n - total_reg));
        stat.build_last = (({1'b0, wptr_reg} + (WADDR_W+1)'(1))
                          == (WADDR_W+1)'(int'(lines) * WORDS_PER_LINE));
        stat.rank_last  = (wptr_reg == q_last);
        stat.lo_lt_hi   = (lo_reg < hi_reg);
        stat.lo_zero    = (lo_reg == '0);
        stat.hit_found  = (k < acc_plus);
        stat.scan_last  = ((int'(wptr_reg) % WORDS_PER_LINE) == (WORDS_PER_LINE - 1));
        stat.out_free   = !out_valid_reg || out_ready;
    end

endmodule

// ===== hw/rtl/bvrs_ctrl.sv =====
// Controller: sequences builds, rank scans and select searches.
module bvrs_ctrl import bvrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  stat_t stat,
    output ctl_t  ctl
);

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_DISPATCH = 19'h00002,
        S_B_RD     = 19'h00004,
        S_B_WR     = 19'h00008,
        S_B_END    = 19'h00010,
        S_RK_RANK  = 19'h00020,
        S_RK_RD    = 19'h00040,
        S_RK_ACC   = 19'h00080,
        S_RK_DONE  = 19'h00100,
        S_SL_MID   = 19'h00200,
        S_SL_CMP   = 19'h00400,
        S_SL_HIT   = 19'h00800,
        S_SL_RD    = 19'h01000,
        S_SL_SCAN  = 19'h02000,
        S_SL_BYTE  = 19'h04000,
        S_SL_BIT   = 19'h08000,
        S_FIN      = 19'h10000,
        S_SPARE0   = 19'h20000,
        S_SPARE1   = 19'h40000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        ctl.res_code = RES_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                ctl.res_set = 1'b1;
                state_next  = S_FIN;
                priority if (stat.cmd == CMD_WRITE)
                begin
                    ctl.wr_word  = stat.widx_ok;
                    ctl.res_code = stat.widx_ok ? RES_OK : RES_RANGE;
                end
                else if (stat.cmd == CMD_BUILD)
                begin
                    ctl.res_set = 1'b0;
                    ctl.b_init  = 1'b1;
                    state_next  = stat.lines_zero ? S_B_END : S_B_RD;
                end
                else if (stat.cmd != CMD_RANK1 && stat.cmd != CMD_SELECT1
                         && stat.cmd != CMD_SELECT0)
                    ctl.res_code = RES_RANGE;
                else if (!stat.dir_valid)
                    ctl.res_code = RES_UNBUILT;
                else if (!stat.q_ok)
                    ctl.res_code = RES_RANGE;
                else if (stat.cmd == CMD_RANK1)
                begin
                    ctl.res_set   = 1'b0;
                    ctl.r_rd_rank = 1'b1;
                    state_next    = S_RK_RANK;
                end
                else
                begin
                    ctl.res_set = 1'b0;
                    ctl.s_init  = 1'b1;
                    state_next  = S_SL_MID;
                end
            end
            S_B_RD:
            begin
                ctl.word_rd = 1'b1;
                state_next  = S_B_WR;
            end
            S_B_WR:
            begin
                ctl.b_wr   = 1'b1;
                state_next = stat.build_last ? S_B_END : S_B_RD;
            end
            S_B_END:
            begin
                ctl.b_end   = 1'b1;
                ctl.res_set = 1'b1;
                state_next  = S_FIN;
            end
            S_RK_RANK:
            begin
                ctl.r_init = 1'b1;
                state_next = S_RK_RD;
            end
            S_RK_RD:
            begin
                ctl.word_rd = 1'b1;
                state_next  = S_RK_ACC;
            end
            S_RK_ACC:
            begin
                ctl.r_acc  = 1'b1;
                state_next = stat.rank_last ? S_RK_DONE : S_RK_RD;
            end
            S_RK_DONE:
            begin
                ctl.res_set  = 1'b1;
                ctl.res_code = RES_ACC;
                state_next   = S_FIN;
            end
            S_SL_MID:
            begin
                priority if (stat.lo_lt_hi)
                begin
                    ctl.s_rd_mid = 1'b1;
                    state_next   = S_SL_CMP;
                end
                else if (stat.lo_zero)
                begin
                    ctl.res_set  = 1'b1;
                    ctl.res_code = RES_RANGE;
                    state_next   = S_FIN;
                end
                else
                begin
                    ctl.s_rd_hit = 1'b1;
                    state_next   = S_SL_HIT;
                end
            end
            S_SL_CMP:
            begin
                ctl.s_cmp  = 1'b1;
                state_next = S_SL_MID;
            end
            S_SL_HIT:
            begin
                ctl.s_hit  = 1'b1;
                state_next = S_SL_RD;
            end
            S_SL_RD:
            begin
                ctl.word_rd = 1'b1;
                state_next  = S_SL_SCAN;
            end
            S_SL_SCAN:
            begin
                priority if (stat.hit_found)
                begin
                    ctl.s_found = 1'b1;
                    state_next  = S_SL_BYTE;
                end
                else if (stat.scan_last)
                begin
                    ctl.res_set  = 1'b1;
                    ctl.res_code = RES_RANGE;
                    state_next   = S_FIN;
                end
                else
                begin
                    ctl.s_next = 1'b1;
                    state_next = S_SL_RD;
                end
            end
            S_SL_BYTE:
            begin
                ctl.s_byte = 1'b1;
                state_next = S_SL_BIT;
            end
            S_SL_BIT:
            begin
                ctl.res_set  = 1'b1;
                ctl.res_code = RES_POS;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== test/tb_bitvector_rank_select.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the rank/select bit vector block.
module tb_bitvector_rank_select import bvrs_pkg::*; ();

    // Commands the block must reject with a range status.
    localparam logic [CMD_W-1:0] CMD_BAD_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BAD_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_BAD_HI  = 3'd7;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_ITEMS = 100;
    localparam int PHASE_ITEMS  = 10;
    localparam int DIR_ROWS     = 15;

    typedef struct packed {
        logic [ANS_W-1:0] answer;
        logic [ST_W-1:0]  status;
    } reply_t;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [WIDX_W-1:0]  widx;
        logic [DATA_W-1:0]  data;
        logic [QUERY_W-1:0] q;
        bit                 typed;
        reply_t             want;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    bvrs_req_if req_if ();
    bvrs_rsp_if rsp_if ();

    bitvector_rank_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // Shadow copy of the block's state, kept by the predictor.
    logic [WORD_WIDTH-1:0] shadow_words [STORE_WORDS];
    bit                    word_written [STORE_WORDS];
    int unsigned           shadow_ranks [LINE_MAX+1];
    int unsigned           shadow_total;
    bit                    shadow_built;
    int unsigned           shadow_count;

    reply_t pending_replies [$];
    int     error_count;
    int     cycle_count;
    int     send_idle_pct;
    int     recv_idle_pct;

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Guard against a hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_bitvector_rank_select: FAIL");
            $finish;
        end
    end

    // Response-side backpressure, changed on the falling edge.
    always @(negedge clk)
    begin
        rsp_if.ready = ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Check each response transaction against the oldest expectation.
    always @(posedge clk)
    begin
        reply_t exp_r;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected response answer=%0d status=%0d",
                         $time, rsp_if.answer, rsp_if.status);
                error_count++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                if (rsp_if.answer !== exp_r.answer)
                begin
                    $display("%0t: answer mismatch expected=%0d actual=%0d",
                             $time, exp_r.answer, rsp_if.answer);
                    error_count++;
                end
                if (rsp_if.status !== exp_r.status)
                begin
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, exp_r.status, rsp_if.status);
                    error_count++;
                end
            end
        end
    end

    function automatic int unsigned used_length();
        return (shadow_count < CAPACITY_BITS) ? shadow_count : CAPACITY_BITS;
    endfunction

    function automatic int unsigned used_lines();
        return (used_length() + LINE_BITS - 1) / LINE_BITS;
    endfunction

    // Zero the tail, count ones per line and record the total.
    function automatic void build_directory();
        int unsigned n;
        int unsigned sum;
        int unsigned w;
        int unsigned base;
        n = used_length();
        sum = 0;
        for (int l = 0; l < used_lines(); l++)
        begin
            shadow_ranks[l] = sum;
            for (int j = 0; j < WORDS_PER_LINE; j++)
            begin
                w = l * WORDS_PER_LINE + j;
                base = w * WORD_WIDTH;
                if (w < STORE_WORDS)
                begin
                    if (base >= n)
                        shadow_words[w] = '0;
                    else if (n - base < WORD_WIDTH)
                        shadow_words[w] &= (64'd1 << (n - base)) - 64'd1;
                    sum += $countones(shadow_words[w]);
                end
            end
        end
        shadow_ranks[used_lines()] = sum;
        shadow_total = sum;
        shadow_built = 1'b1;
    endfunction

    function automatic int unsigned ones_before(int unsigned pos);
        int unsigned line;
        int unsigned r;
        line = pos / LINE_BITS;
        r = shadow_ranks[line];
        for (int unsigned w = line * WORDS_PER_LINE; w < pos / WORD_WIDTH; w++)
            r += $countones(shadow_words[w]);
        if (pos % WORD_WIDTH != 0)
            r += $countones(shadow_words[pos / WORD_WIDTH]
                            & ((64'd1 << (pos % WORD_WIDTH)) - 64'd1));
        return r;
    endfunction

    function automatic int unsigned count_before_line(int unsigned l, bit zeros);
        return zeros ? l * LINE_BITS - shadow_ranks[l] : shadow_ranks[l];
    endfunction

    // Upper-bound search over the directory, then scan the line's words.
    function automatic bit locate_kth(int unsigned k, bit zeros, output int unsigned pos);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned hit;
        int unsigned c;
        int unsigned seen;
        logic [WORD_WIDTH-1:0] v;
        lo = 0;
        hi = used_lines();
        pos = 0;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (count_before_line(mid, zeros) <= k)
                lo = mid + 1;
            else
                hi = mid;
        end
        if (lo == 0)
            return 1'b0;
        hit = count_before_line(lo - 1, zeros);
        for (int i = 0; i < WORDS_PER_LINE; i++)
        begin
            v = ((lo - 1) * WORDS_PER_LINE + i < STORE_WORDS)
                ? shadow_words[(lo - 1) * WORDS_PER_LINE + i] : '0;
            if (zeros)
                v = ~v;
            c = $countones(v);
            if (k < hit + c)
            begin
                seen = 0;
                for (int b = 0; b < WORD_WIDTH; b++)
                begin
                    if (v[b])
                    begin
                        if (seen == k - hit)
                        begin
                            pos = (lo - 1) * LINE_BITS + i * WORD_WIDTH + b;
                            return 1'b1;
                        end
                        seen++;
                    end
                end
            end
            hit += c;
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow state and return its response.
    function automatic reply_t predict_reply(logic [CMD_W-1:0] cmd, logic [WIDX_W-1:0] widx,
                                             logic [DATA_W-1:0] data,
                                             logic [QUERY_W-1:0] q);
        reply_t r;
        int unsigned n;
        int unsigned pos;
        n = used_length();
        r.answer = '0;
        r.status = ST_OK;
        if (cmd == CMD_WRITE)
        begin
            shadow_words[widx] = data[WORD_WIDTH-1:0];
            word_written[widx] = 1'b1;
            shadow_built = 1'b0;
        end
        else if (cmd == CMD_BUILD)
            build_directory();
        else if (cmd > CMD_SELECT0)
            r.status = ST_RANGE;
        else if (!shadow_built)
            r.status = ST_UNBUILT;
        else if (cmd == CMD_RANK1)
        begin
            if (q < n)
                r.answer = ANS_W'(ones_before(q));
            else
                r.status = ST_RANGE;
        end
        else if (cmd == CMD_SELECT1)
        begin
            if (q < shadow_total && locate_kth(q, 1'b0, pos))
                r.answer = ANS_W'(pos);
            else
                r.status = ST_RANGE;
        end
        else
        begin
            if (q < n - shadow_total && locate_kth(q, 1'b1, pos))
                r.answer = ANS_W'(pos);
            else
                r.status = ST_RANGE;
        end
        return r;
    endfunction

    // Drive one request transaction; call and return at a falling edge.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [WIDX_W-1:0] widx,
                                logic [DATA_W-1:0] data, logic [QUERY_W-1:0] q,
                                bit typed = 1'b0, reply_t want = '0);
        reply_t r;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid      = 1'b1;
        req_if.command    = cmd;
        req_if.word_index = widx;
        req_if.word_data  = data;
        req_if.query      = q;
        do
            @(posedge clk);
        while (!req_if.ready);
        r = predict_reply(cmd, widx, data, q);
        pending_replies.push_back(typed ? want : r);
        @(negedge clk);
        req_if.valid = 1'b0;
    endtask

    // Drain, let the block settle, then write the length register.
    task automatic set_length(logic [CNT_W-1:0] value);
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        shadow_count = 32'(value);
        shadow_built = 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return '1;
            2: return {32'h0, $urandom} << $urandom_range(63, 0);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [QUERY_W-1:0] clip_query(int unsigned v);
        return (v > 65535) ? 16'hFFFF : v[QUERY_W-1:0];
    endfunction

    // Random query with k or position mostly near the valid range.
    task automatic random_query();
        int unsigned n;
        int unsigned pick;
        logic [QUERY_W-1:0] q;
        logic [CMD_W-1:0] cmd;
        n = used_length();
        pick = $urandom_range(2, 0);
        cmd = (pick == 0) ? CMD_RANK1 : (pick == 1) ? CMD_SELECT1 : CMD_SELECT0;
        if ($urandom_range(9, 0) == 0)
            q = QUERY_W'($urandom);
        else if (cmd == CMD_RANK1)
            q = clip_query($urandom_range(n + 1, 0));
        else if (cmd == CMD_SELECT1)
            q = clip_query($urandom_range(shadow_total + 1, 0));
        else
            q = clip_query($urandom_range(n - shadow_total + 1, 0));
        send_request(cmd, WIDX_W'($urandom), random_word(), q);
    endtask

    // One length setting: fill the used lines, build, then mixed traffic.
    task automatic run_phase(logic [CNT_W-1:0] length_value, int count);
        int unsigned roll;
        set_length(length_value);
        for (int w = 0; w < used_lines() * WORDS_PER_LINE && w < STORE_WORDS; w++)
            if (!word_written[w])
                send_request(CMD_WRITE, WIDX_W'(w), random_word(), QUERY_W'($urandom));
        random_query();
        send_request(CMD_BUILD, WIDX_W'($urandom), random_word(), QUERY_W'($urandom));
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 84)
                random_query();
            else if (roll < 91)
            begin
                // Rewrite a word, usually one inside the used lines.
                if (used_lines() != 0 && $urandom_range(3, 0) != 0)
                    send_request(CMD_WRITE,
                                 WIDX_W'($urandom_range(used_lines() * WORDS_PER_LINE - 1, 0)),
                                 random_word(), QUERY_W'($urandom));
                else
                    send_request(CMD_WRITE, WIDX_W'($urandom), random_word(),
                                 QUERY_W'($urandom));
            end
            else if (roll < 98)
                send_request(CMD_BUILD, WIDX_W'($urandom), random_word(),
                             QUERY_W'($urandom));
            else
                send_request(CMD_W'($urandom_range(CMD_BAD_HI, CMD_BAD_LO)),
                             WIDX_W'($urandom), random_word(), QUERY_W'($urandom));
        end
    endtask

    initial
    begin
        row_t dir_rows [DIR_ROWS];
        int   random_done;
        int   phase_no;
        logic [CNT_W-1:0] lengths [10];

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.command = CMD_WRITE;
        req_if.word_index = '0;
        req_if.word_data = '0;
        req_if.query = '0;
        rsp_if.ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 38;
        recv_idle_pct = 83;
        shadow_total = 0;
        shadow_built = 1'b0;
        shadow_count = 0;
        foreach (word_written[i])
        begin
            word_written[i] = 1'b0;
            shadow_words[i] = '0;
        end
        foreach (shadow_ranks[i])
            shadow_ranks[i] = 0;

        // Directed checks at length zero, where nothing reads the store.
        dir_rows[0]  = '{CMD_RANK1, 0, 0, 0, 1, '{0, ST_UNBUILT}};
        dir_rows[1]  = '{CMD_SELECT1, 0, 0, 16'hFFFF, 1, '{0, ST_UNBUILT}};
        dir_rows[2]  = '{CMD_SELECT0, 0, 0, 0, 1, '{0, ST_UNBUILT}};
        dir_rows[3]  = '{CMD_BAD_LO, 0, 0, 0, 1, '{0, ST_RANGE}};
        dir_rows[4]  = '{CMD_BAD_MID, 10'h3FF, '1, 16'hFFFF, 1, '{0, ST_RANGE}};
        dir_rows[5]  = '{CMD_BAD_HI, 0, 0, 0, 1, '{0, ST_RANGE}};
        dir_rows[6]  = '{CMD_WRITE, 0, '1, 16'hFFFF, 1, '{0, ST_OK}};
        dir_rows[7]  = '{CMD_WRITE, 10'h3FF, 0, 0, 1, '{0, ST_OK}};
        dir_rows[8]  = '{CMD_WRITE, 10'h2AA, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1, '{0, ST_OK}};
        dir_rows[9]  = '{CMD_BUILD, 0, 0, 0, 1, '{0, ST_OK}};
        dir_rows[10] = '{CMD_RANK1, 0, 0, 0, 1, '{0, ST_RANGE}};
        dir_rows[11] = '{CMD_RANK1, 0, 0, 16'hFFFF, 1, '{0, ST_RANGE}};
        dir_rows[12] = '{CMD_SELECT1, 0, 0, 0, 1, '{0, ST_RANGE}};
        dir_rows[13] = '{CMD_SELECT0, 0, 0, 0, 1, '{0, ST_RANGE}};
        dir_rows[14] = '{CMD_SELECT0, 10'h155, 64'h5555_5555_5555_5555, 16'hFFFF, 1,
                         '{0, ST_RANGE}};

        lengths = '{17'd65536, 17'h1FFFF, 17'd1, 17'd63, 17'd64, 17'd65,
                    17'd255, 17'd256, 17'd257, 17'd0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Write the register once right after reset, to zero.
        set_length('0);
        foreach (dir_rows[i])
            send_request(dir_rows[i].cmd, dir_rows[i].widx, dir_rows[i].data,
                         dir_rows[i].q, dir_rows[i].typed, dir_rows[i].want);

        // Full store first so later phases need no fill.
        random_done = 0;
        phase_no = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            // Advance the idle profile as the run goes on.
            if (phase_no == 4)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 38;
            end
            else if (phase_no == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase_no < 10)
                run_phase(lengths[phase_no], PHASE_ITEMS);
            else if ($urandom_range(3, 0) == 0)
                run_phase(CNT_W'($urandom_range(65536, 1)), PHASE_ITEMS);
            else
                run_phase(CNT_W'($urandom_range(4096, 1)), PHASE_ITEMS);
            random_done += PHASE_ITEMS;
            phase_no++;
        end

        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (error_count == 0)
            $display("tb_bitvector_rank_select: PASS");
        else
            $display("tb_bitvector_rank_select: FAIL");
        $finish;
    end
endmodule
